// ----- sv/lae_pkg.sv -----
// shared constants, tables and side-band type of the loop amplitude evaluator
package lae_pkg;

    localparam int FRAC_BITS = 20;
    localparam int IQ        = 40;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int YQ_W      = IN_W + IQ - FRAC_BITS;
    localparam int SQRT_N    = (YQ_W + IQ + 1) / 2;
    localparam int ROOT_W    = SQRT_N;
    localparam int REM_W     = ROOT_W + 4;
    localparam int CORDIC_N  = 42;
    localparam int XW        = ROOT_W + 3;
    localparam int ZW        = 44;
    localparam int LOG_N     = IQ;
    localparam int ZN_W      = 63;
    localparam int M_W       = $clog2(YQ_W);
    localparam int LG_W      = IQ + M_W + 1;
    localparam int MUL_LAT   = 3;
    localparam int LOG_LAT   = 2 * LOG_N + 3;

    // register counts from the input port to each intermediate result
    localparam int T_S   = SQRT_N;
    localparam int T_LOG = T_S + LOG_LAT;
    localparam int T_LG  = T_LOG + 1 + MUL_LAT;
    localparam int T_P   = T_LG + MUL_LAT;
    localparam int T_F   = T_P + 1;
    localparam int T_TH  = T_S + CORDIC_N + MUL_LAT;
    localparam int DLY   = T_P - T_TH;
    localparam int T_M1  = T_F + MUL_LAT;
    localparam int T_M2  = T_M1 + MUL_LAT;
    localparam int SB_N  = T_M2;

    localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< IQ;
    localparam logic signed [63:0] PI_Q   = 64'sh3243F6A8886;
    localparam logic signed [63:0] LN2_Q  = 64'shB17217F7D2;
    localparam logic [127:0]       PI_PROD = 128'(PI_Q) * 128'(PI_Q);
    localparam logic signed [63:0] PI_SQ_Q = signed'(PI_PROD[103:40]);

    typedef logic [CORDIC_N-1:0][ZW-1:0] t_atan_tab;

    // atan(2^-i) in Q.40 from its power series, entry 0 is pi/4
    function automatic t_atan_tab build_atan();
        t_atan_tab  tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        tab[0] = ZW'(PI_Q >>> 2);
        for (int i = 1; i < CORDIC_N; i++) begin
            acc = '0;
            for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e <= 62) begin
                    term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                    if ((k & 1) == 0) begin
                        acc = acc + term;
                    end else begin
                        acc = acc - term;
                    end
                end
            end
            tab[i] = ZW'((acc + (64'd1 << 21)) >> 22);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan();

    typedef struct packed {
        logic            cmd;
        logic [IN_W-1:0] ratio;
    } t_sb;

    function automatic logic [YQ_W-1:0] yq_of(input logic [IN_W-1:0] ratio);
        return {ratio, {(IQ - FRAC_BITS){1'b0}}};
    endfunction

endpackage

// ----- sv/lae_smul.sv -----
// pipelined saturating signed Q.40 multiplier, three stages
module lae_smul import lae_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_ma, r_mb;
    logic         r_neg1, r_neg2;
    logic [63:0]  r_p0, r_p1, r_p2, r_p3;
    logic [127:0] w_full;
    logic [62:0]  w_mag;
    logic signed [63:0] r_p;

    assign w_full = {r_p3, 64'd0} + {32'd0, r_p1, 32'd0} + {32'd0, r_p2, 32'd0}
                  + {64'd0, r_p0};
    assign w_mag  = (|w_full[127:103]) ? {63{1'b1}} : w_full[102:40];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[63] ? 64'd0 - i_a : i_a;
            r_mb   <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg1 <= i_a[63] ^ i_b[63];
            r_p0   <= r_ma[31:0] * r_mb[31:0];
            r_p1   <= r_ma[31:0] * r_mb[63:32];
            r_p2   <= r_ma[63:32] * r_mb[31:0];
            r_p3   <= r_ma[63:32] * r_mb[63:32];
            r_neg2 <= r_neg1;
            r_p    <= r_neg2 ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});
        end
    end

    assign o_p = r_p;

endmodule

// ----- sv/lae_sqrt.sv -----
// digit-by-digit square root, one result bit per pipeline stage
module lae_sqrt import lae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [YQ_W-1:0]   i_v,
    output logic [ROOT_W-1:0] o_root
);

    logic [YQ_W-1:0]   r_v    [SQRT_N];
    logic [REM_W-1:0]  r_rem  [SQRT_N];
    logic [ROOT_W-1:0] r_root [SQRT_N];

    for (genvar j = 0; j < SQRT_N; j++) begin : g_stage
        localparam int BIT_POS = 2 * (SQRT_N - 1 - j);
        logic [YQ_W-1:0]     w_v;
        logic [REM_W-1:0]    w_rem, w_sh, w_trial, n_rem;
        logic [ROOT_W-1:0]   w_root, n_root;
        logic [2*SQRT_N-1:0] w_x;
        logic                w_ge;

        if (j == 0) begin : g_first
            assign w_v    = i_v;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_v    = r_v[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        // radicand is the input scaled up by 2^IQ
        assign w_x     = (2 * SQRT_N)'({w_v, {IQ{1'b0}}});
        assign w_sh    = {w_rem[REM_W-3:0], w_x[BIT_POS +: 2]};
        assign w_trial = REM_W'({w_root, 2'b01});
        assign w_ge    = w_sh >= w_trial;
        assign n_root  = {w_root[ROOT_W-2:0], w_ge};
        assign n_rem   = w_ge ? w_sh - w_trial : w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j]    <= w_v;
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQRT_N-1];

endmodule

// ----- sv/lae_cordic.sv -----
// circular cordic in vectoring mode, atan2(1, x), one micro-rotation per stage
module lae_cordic import lae_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ROOT_W-1:0]    i_x,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x [CORDIC_N];
    logic signed [XW-1:0] r_y [CORDIC_N];
    logic signed [ZW-1:0] r_z [CORDIC_N];

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
        logic signed [XW-1:0] w_x, w_y, n_x, n_y;
        logic signed [ZW-1:0] w_z, n_z;

        if (i == 0) begin : g_first
            assign w_x = signed'(XW'(i_x));
            assign w_y = signed'(XW'(ONE_Q));
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end

        always_comb begin
            if (w_y > 0) begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + signed'(ATAN_TAB[i]);
            end else begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - signed'(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    assign o_z = r_z[CORDIC_N-1];

endmodule

// ----- sv/lae_log.sv -----
// base-2 logarithm in Q.40: leading one, then one fraction bit per squaring
module lae_log import lae_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [YQ_W-1:0]        i_v,
    output logic signed [LG_W-1:0] o_l
);

    logic [M_W-1:0]   w_m;
    logic [M_W-1:0]   r_m0, r_m1;
    logic [YQ_W-1:0]  r_v0;
    logic [ZN_W-1:0]  r_z1;

    logic [61:0]      r_hh [LOG_N];
    logic [62:0]      r_hl [LOG_N];
    logic [63:0]      r_ll [LOG_N];
    logic [LOG_N-1:0] r_fa [LOG_N];
    logic [M_W-1:0]   r_ma [LOG_N];
    logic [ZN_W-1:0]  r_zb [LOG_N];
    logic [LOG_N-1:0] r_fb [LOG_N];
    logic [M_W-1:0]   r_mb [LOG_N];

    logic signed [M_W:0]    w_int;
    logic signed [LG_W-1:0] r_l;

    always_comb begin
        w_m = '0;
        for (int b = 0; b < YQ_W; b++) begin
            if (i_v[b]) begin
                w_m = M_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= w_m;
            r_v0 <= i_v;
            // mantissa normalized to Q.62
            r_z1 <= ZN_W'(r_v0) << (M_W'(ZN_W - 1) - r_m0);
            r_m1 <= r_m0;
        end
    end

    for (genvar k = 0; k < LOG_N; k++) begin : g_step
        logic [ZN_W-1:0]  w_z, n_z;
        logic [LOG_N-1:0] w_f;
        logic [M_W-1:0]   w_mm;
        logic [125:0]     w_full;
        logic [63:0]      w_sq;

        if (k == 0) begin : g_first
            assign w_z  = r_z1;
            assign w_f  = '0;
            assign w_mm = r_m1;
        end else begin : g_next
            assign w_z  = r_zb[k-1];
            assign w_f  = r_fb[k-1];
            assign w_mm = r_mb[k-1];
        end

        assign w_full = {r_hh[k], 64'd0} + {30'd0, r_hl[k], 33'd0} + {62'd0, r_ll[k]};
        assign w_sq   = w_full[125:62];
        assign n_z    = w_sq[63] ? w_sq[63:1] : w_sq[62:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hh[k] <= w_z[62:32] * w_z[62:32];
                r_hl[k] <= w_z[62:32] * w_z[31:0];
                r_ll[k] <= w_z[31:0] * w_z[31:0];
                r_fa[k] <= w_f;
                r_ma[k] <= w_mm;
                r_zb[k] <= n_z;
                r_fb[k] <= {r_fa[k][LOG_N-2:0], w_sq[63]};
                r_mb[k] <= r_ma[k];
            end
        end
    end

    assign w_int = signed'({1'b0, r_mb[LOG_N-1]}) - (M_W + 1)'(IQ);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l <= {w_int, r_fb[LOG_N-1]};
        end
    end

    assign o_l = r_l;

endmodule

// ----- sv/loop_amplitude_evaluator.sv -----
// top level: scalar-loop amplitude pipeline with side-band and output register
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------------------------
//  in      | i_valid | o_stall | i_command, i_ratio_y
//  out     | o_valid | i_stall | o_real_part, o_imag_part, o_invalid
//
// one transaction per cycle while o_stall is low. Data passes the square root,
// the 40 squaring steps of the log unit and the chained three-stage
// multipliers.
// all stages share one enable; the pipeline freezes only while a result sits
// in the output register and the consumer stalls.
// reset clears the valid bits only.
module loop_amplitude_evaluator import lae_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_command,
    input  logic [IN_W-1:0]         i_ratio_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_real_part,
    output logic signed [OUT_W-1:0] o_imag_part,
    output logic                    o_invalid
);

    logic w_en;

    logic [SB_N-1:0] r_vld;
    t_sb             r_sb [SB_N];

    logic [YQ_W-1:0]   w_yq, w_one, w_sv;
    logic [ROOT_W-1:0] w_root;
    logic signed [LG_W-1:0] w_l1, w_l0;
    logic signed [LG_W+1:0] w_d;
    logic signed [63:0] r_d;
    logic signed [63:0] w_lg, w_lg2, w_lgpi;
    logic signed [ZW-1:0] w_th;
    logic signed [63:0] w_frc;
    logic signed [63:0] r_frc_d [DLY];
    logic signed [63:0] r_fr, r_fi;
    logic signed [63:0] w_w, w_a, w_pr1, w_pi1, w_pr2, w_pi2;
    logic signed [63:0] w_base, w_re_t, w_re, w_im;
    logic [OUT_W:0]     w_ore, w_oim;

    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_real, r_o_imag;
    logic                    r_o_invalid;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -a;
    endfunction

    // {clamped flag, value} after dropping 16 fraction bits
    function automatic logic [OUT_W:0] to_out(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v >>> 16;
        if (w > 64'sh7FFF_FFFF) begin
            return {1'b1, 1'b0, {(OUT_W - 1){1'b1}}};
        end else if (w < -64'sh8000_0000) begin
            return {1'b1, 1'b1, {(OUT_W - 1){1'b0}}};
        end
        return {1'b0, w[OUT_W-1:0]};
    endfunction

    assign w_en    = ~r_o_valid | ~i_stall;
    assign o_stall = ~w_en;

    // side-band: valid, loop kind and ratio travel beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[SB_N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= '{cmd: i_command, ratio: i_ratio_y};
            for (int k = 1; k < SB_N; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // root of |y - 1|
    assign w_yq  = yq_of(i_ratio_y);
    assign w_one = YQ_W'(ONE_Q);
    assign w_sv  = (w_yq >= w_one) ? w_yq - w_one : w_one - w_yq;

    lae_sqrt u_sqrt (.i_clk(i_clk), .i_en(w_en), .i_v(w_sv), .o_root(w_root));

    // y >= 1: asin(1/sqrt y) = atan2(1, sqrt(y-1))
    lae_cordic u_cordic (.i_clk(i_clk), .i_en(w_en), .i_x(w_root), .o_z(w_th));

    lae_smul u_mul_th (.i_clk(i_clk), .i_en(w_en), .i_a(64'(w_th)), .i_b(64'(w_th)),
                       .o_p(w_frc));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_frc_d[0] <= w_frc;
            for (int k = 1; k < DLY; k++) begin
                r_frc_d[k] <= r_frc_d[k-1];
            end
        end
    end

    // y < 1: L = ln2 * (2 log2(1+s) - log2 y)
    lae_log u_log1 (.i_clk(i_clk), .i_en(w_en), .i_v(YQ_W'(w_root) + w_one), .o_l(w_l1));
    lae_log u_log0 (.i_clk(i_clk), .i_en(w_en), .i_v(yq_of(r_sb[T_S-1].ratio)),
                    .o_l(w_l0));

    assign w_d = {w_l1[LG_W-1], w_l1, 1'b0} - {{2{w_l0[LG_W-1]}}, w_l0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d <= 64'(w_d);
        end
    end

    lae_smul u_mul_lg (.i_clk(i_clk), .i_en(w_en), .i_a(r_d), .i_b(LN2_Q), .o_p(w_lg));
    lae_smul u_mul_sq (.i_clk(i_clk), .i_en(w_en), .i_a(w_lg), .i_b(w_lg), .o_p(w_lg2));
    lae_smul u_mul_lp (.i_clk(i_clk), .i_en(w_en), .i_a(w_lg), .i_b(PI_Q), .o_p(w_lgpi));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sb[T_P-1].ratio[IN_W-1:FRAC_BITS] != '0) begin
                r_fr <= r_frc_d[DLY-1];
                r_fi <= '0;
            end else begin
                r_fr <= (PI_SQ_Q - w_lg2) >>> 2;
                r_fi <= w_lgpi >>> 1;
            end
        end
    end

    // fermion: w = 1 - y, a = y; vector: w = 2 - y, a = 3y
    assign w_w = r_sb[T_F-1].cmd ? (ONE_Q <<< 1) - 64'(yq_of(r_sb[T_F-1].ratio))
                                 : ONE_Q - 64'(yq_of(r_sb[T_F-1].ratio));
    assign w_a = r_sb[T_M1-1].cmd ? 64'(yq_of(r_sb[T_M1-1].ratio)) * 64'd3
                                  : 64'(yq_of(r_sb[T_M1-1].ratio));

    lae_smul u_mul_wr (.i_clk(i_clk), .i_en(w_en), .i_a(w_w), .i_b(r_fr), .o_p(w_pr1));
    lae_smul u_mul_wi (.i_clk(i_clk), .i_en(w_en), .i_a(w_w), .i_b(r_fi), .o_p(w_pi1));
    lae_smul u_mul_ar (.i_clk(i_clk), .i_en(w_en), .i_a(w_a), .i_b(w_pr1), .o_p(w_pr2));
    lae_smul u_mul_ai (.i_clk(i_clk), .i_en(w_en), .i_a(w_a), .i_b(w_pi1), .o_p(w_pi2));

    assign w_base = r_sb[T_M2-1].cmd
                  ? (ONE_Q <<< 1) + 64'(yq_of(r_sb[T_M2-1].ratio)) * 64'd3
                  : 64'(yq_of(r_sb[T_M2-1].ratio));
    assign w_re_t = sat_add(w_base, w_pr2);
    assign w_re   = r_sb[T_M2-1].cmd ? sat_neg(w_re_t) : w_re_t;
    assign w_im   = r_sb[T_M2-1].cmd ? sat_neg(w_pi2) : w_pi2;
    assign w_ore  = to_out(w_re);
    assign w_oim  = to_out(w_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_vld[T_M2-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sb[T_M2-1].ratio == '0) begin
                r_o_real    <= '0;
                r_o_imag    <= '0;
                r_o_invalid <= 1'b1;
            end else begin
                r_o_real    <= w_ore[OUT_W-1:0];
                r_o_imag    <= w_oim[OUT_W-1:0];
                r_o_invalid <= w_ore[OUT_W] | w_oim[OUT_W];
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_real_part = r_o_real;
    assign o_imag_part = r_o_imag;
    assign o_invalid   = r_o_invalid;

endmodule
